/* hw/rtl/icmp_rw_pkg.sv */
package icmp_rw_pkg;

  // Held header: 14 Ethernet, 20 IPv4 and 16 ICMP bytes.
  localparam int HdrLen = 14 + 20 + 16;
  localparam int IdxW = $clog2(HdrLen + 1);

  localparam logic [15:0] EtypeIp4 = 16'h0800;
  localparam logic [3:0] IpVer4 = 4'h4;
  localparam logic [7:0] ProtoIcmp = 8'h01;
  localparam logic [7:0] IcmpReq = 8'h08;
  localparam logic [7:0] IcmpRep = 8'h00;
  localparam logic [15:0] IcmpFix = 16'h0800;

  // Codes of the frame_kind field.
  localparam logic [1:0] KindOther = 2'd0;
  localparam logic [1:0] KindReq = 2'd1;
  localparam logic [1:0] KindRep = 2'd2;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
  } req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_end;
    logic [1:0] frame_kind;
  } rsp_t;

endpackage

/* hw/rtl/icmp_echo_reply_rewriter.sv */
// ICMP echo reply rewriter.
// The req channel carries one frame byte per word, with frame_end on the last
// byte of each frame. The rsp channel returns the frame byte by byte, with
// out_end on the last byte and frame_kind telling whether the frame was an
// echo request turned into a reply, an echo reply, or anything else.
// The first 50 bytes of a frame are written into a 50-byte header memory at
// one byte per cycle. When the fiftieth byte arrives, the sequencer runs the
// shared 20-bit adder: two folds of the IP header sum and the ICMP checksum
// fix-up with its end-around carry. The held bytes then leave one at a time,
// each one a registered memory read followed by a load of the output register.
// A frame that ends before 50 bytes skips the adder steps and is replayed
// unchanged. After the header, the rest of the frame passes through the output
// register at one byte per cycle while the receiver keeps up.
// The block takes no input while it replays a header. After the last header byte the
// adder states run, then the read and output states; a short frame skips the adder states.
// When the receiver stalls, the output word is held and the block waits; during
// pass-through the input is held off until the output register is free.
// A synchronous reset returns the block to collecting a new frame and drops
// any pending output word.
module icmp_echo_reply_rewriter (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  icmp_rw_pkg::req_t  req_word,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output icmp_rw_pkg::rsp_t  rsp_word
);
  import icmp_rw_pkg::*;

  typedef enum logic [2:0] {
    S_COLLECT,
    S_FOLD1,
    S_FOLD2,
    S_ICMP1,
    S_ICMP2,
    S_RD,
    S_OUT,
    S_PASS
  } state_t;

  localparam logic [IdxW-1:0] LastIdx = IdxW'(HdrLen - 1);

  state_t          state;
  logic [IdxW-1:0] count;
  logic [IdxW-1:0] idx;
  logic [IdxW-1:0] rd_addr;
  logic [7:0]      mem [HdrLen];
  logic [7:0]      rd_data;
  logic [7:0]      prev_byte;
  logic [7:0]      b12, b13, b14, b23, b34;
  logic [19:0]     acc;
  logic [19:0]     icmp_sum;
  logic [19:0]     add_a, add_b, add_sum;
  logic            end_seen;
  logic [1:0]      kind;
  logic [1:0]      kind_next;
  logic            req_accept;
  logic            slot_free;
  logic            rsp_load;
  logic            add_word;
  logic [7:0]      byte_sel;
  logic            last_idx;

  assign slot_free = !rsp_valid || rsp_ready;
  assign req_ready = (state == S_COLLECT) || ((state == S_PASS) && slot_free);
  assign req_accept = req_valid && req_ready;
  assign last_idx = (idx == IdxW'(count - IdxW'(1)));

  // The output register takes a new word on a header replay step or a pass-through byte.
  assign rsp_load = ((state == S_OUT) && slot_free) || ((state == S_PASS) && req_accept);

  // Header words are summed as they arrive; the checksum field is left out.
  assign add_word = count[0] && (count >= IdxW'(15)) && (count <= IdxW'(33)) &&
                    (count != IdxW'(25));

  // The one shared adder, steered by the sequencer state.
  always_comb begin
    add_a = '0;
    add_b = '0;
    case (state)
      S_COLLECT: begin
        add_a = acc;
        add_b = {4'b0, prev_byte, req_word.frame_byte};
      end
      S_FOLD1, S_FOLD2: begin
        add_a = {4'b0, acc[15:0]};
        add_b = {16'b0, acc[19:16]};
      end
      S_ICMP1: begin
        add_a = icmp_sum;
        add_b = {4'b0, IcmpFix};
      end
      S_ICMP2: begin
        add_a = {4'b0, icmp_sum[15:0]};
        add_b = {16'b0, icmp_sum[19:16]};
      end
      default: begin
        add_a = '0;
        add_b = '0;
      end
    endcase
  end
  assign add_sum = add_a + add_b;

  always_comb begin
    if ({b12, b13} != EtypeIp4 || b14[7:4] != IpVer4 || b23 != ProtoIcmp) begin
      kind_next = KindOther;
    end else if (b34 == IcmpReq) begin
      kind_next = KindReq;
    end else if (b34 == IcmpRep) begin
      kind_next = KindRep;
    end else begin
      kind_next = KindOther;
    end
  end

  // A reply swaps the MAC and IPv4 address pairs, which is just a remapped read.
  always_comb begin
    rd_addr = idx;
    if (kind == KindReq) begin
      if (idx < IdxW'(6)) begin
        rd_addr = IdxW'(idx + IdxW'(6));
      end else if (idx < IdxW'(12)) begin
        rd_addr = IdxW'(idx - IdxW'(6));
      end else if (idx >= IdxW'(26) && idx < IdxW'(30)) begin
        rd_addr = IdxW'(idx + IdxW'(4));
      end else if (idx >= IdxW'(30) && idx < IdxW'(34)) begin
        rd_addr = IdxW'(idx - IdxW'(4));
      end
    end
  end

  always_comb begin
    byte_sel = rd_data;
    if (kind == KindReq) begin
      if (idx == IdxW'(24)) begin
        byte_sel = ~acc[15:8];
      end else if (idx == IdxW'(25)) begin
        byte_sel = ~acc[7:0];
      end else if (idx == IdxW'(34)) begin
        byte_sel = IcmpRep;
      end else if (idx == IdxW'(36)) begin
        byte_sel = icmp_sum[15:8];
      end else if (idx == IdxW'(37)) begin
        byte_sel = icmp_sum[7:0];
      end
    end
  end

  // Header memory: one write port while collecting, one registered read port.
  always_ff @(posedge clk) begin
    if (state == S_COLLECT && req_accept) begin
      mem[count[IdxW-1:0]] <= req_word.frame_byte;
    end
    if (state == S_RD) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_COLLECT;
      count <= '0;
      idx <= '0;
      kind <= KindOther;
      end_seen <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_COLLECT: begin
          if (req_accept) begin
            prev_byte <= req_word.frame_byte;
            if (count == '0) begin
              acc <= '0;
            end else if (add_word) begin
              acc <= add_sum;
            end
            if (count == IdxW'(12)) b12 <= req_word.frame_byte;
            if (count == IdxW'(13)) b13 <= req_word.frame_byte;
            if (count == IdxW'(14)) b14 <= req_word.frame_byte;
            if (count == IdxW'(23)) b23 <= req_word.frame_byte;
            if (count == IdxW'(34)) b34 <= req_word.frame_byte;
            if (count == IdxW'(36)) icmp_sum <= {4'b0, req_word.frame_byte, 8'h00};
            if (count == IdxW'(37)) icmp_sum[7:0] <= req_word.frame_byte;
            count <= IdxW'(count + IdxW'(1));
            idx <= '0;
            if (count == LastIdx) begin
              kind <= kind_next;
              end_seen <= req_word.frame_end;
              state <= S_FOLD1;
            end else if (req_word.frame_end) begin
              kind <= KindOther;
              end_seen <= 1'b1;
              state <= S_RD;
            end
          end
        end
        S_FOLD1: begin
          acc <= add_sum;
          state <= S_FOLD2;
        end
        S_FOLD2: begin
          acc <= add_sum;
          state <= S_ICMP1;
        end
        S_ICMP1: begin
          icmp_sum <= add_sum;
          state <= S_ICMP2;
        end
        S_ICMP2: begin
          icmp_sum <= add_sum;
          state <= S_RD;
        end
        S_RD: begin
          state <= S_OUT;
        end
        S_OUT: begin
          if (slot_free) begin
            rsp_word.out_byte <= byte_sel;
            rsp_word.out_end <= last_idx && end_seen;
            rsp_word.frame_kind <= kind;
            if (last_idx) begin
              count <= '0;
              if (end_seen) begin
                kind <= KindOther;
                state <= S_COLLECT;
              end else begin
                state <= S_PASS;
              end
            end else begin
              idx <= IdxW'(idx + IdxW'(1));
              state <= S_RD;
            end
          end
        end
        S_PASS: begin
          if (req_accept) begin
            rsp_word.out_byte <= req_word.frame_byte;
            rsp_word.out_end <= req_word.frame_end;
            rsp_word.frame_kind <= kind;
            if (req_word.frame_end) begin
              kind <= KindOther;
              state <= S_COLLECT;
            end
          end
        end
        default: begin
          state <= S_COLLECT;
        end
      endcase
    end
  end

endmodule

/* hw/rtl/icmp_rw_checker.sv */
module icmp_rw_checker (
  input logic               clk,
  input logic               rst,
  input logic               req_valid,
  input logic               req_ready,
  input icmp_rw_pkg::req_t  req_word,
  input logic               rsp_valid,
  input logic               rsp_ready,
  input icmp_rw_pkg::rsp_t  rsp_word
);
  import icmp_rw_pkg::*;

  // No output word survives a reset.
  a_reset_clears: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("output word valid right after reset");

  // A stalled output word stays offered.
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("output word dropped while stalled");

  // The kind code is never the unused value.
  a_kind_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_word.frame_kind == KindOther || rsp_word.frame_kind == KindReq ||
                   rsp_word.frame_kind == KindRep))
    else $error("unused frame kind code");

  // A stalled output word keeps its contents.
  a_hold_word: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(rsp_word))
    else $error("output word changed while stalled");

endmodule

bind icmp_echo_reply_rewriter icmp_rw_checker u_icmp_rw_checker (.*);

/* bench/tb_icmp_echo_reply_rewriter.sv */
`timescale 1ns / 100ps

// Testbench for the ICMP echo reply rewriter.
// Frames go in one byte per word on the req channel. Every accepted word is
// also fed to a behavioral copy of the rewriter kept in this module. The words
// it expects are appended to a queue, unless the row gives the expected words,
// and the rsp monitor checks each returned word against the oldest entry.
module tb_icmp_echo_reply_rewriter;
  import icmp_rw_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int TailCycles = 20;
  localparam int RandomBytes = 130;
  localparam int IdlePct = 31;

  // Frame shapes that the stimulus builder knows how to produce.
  typedef enum logic [2:0] {
    ShapeNoise,
    ShapeNonIp,
    ShapeBadVer,
    ShapeBadProto,
    ShapeOtherType,
    ShapeReq,
    ShapeRep
  } shape_t;

  // One frame of stimulus. A fill below zero means random bytes. When typed
  // is set, the frame is not a request, so every byte is expected back
  // unchanged with the kind given in the row.
  typedef struct packed {
    shape_t      shape;
    int          len;
    int          fill;
    logic        ck_set;
    logic [15:0] ck;
    logic        typed;
    logic [1:0]  kind;
  } frame_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req_word = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp_word;

  int errors = 0;
  int cycles = 0;

  // While steady is set, neither side idles.
  logic steady = 1'b0;

  // Bytes of the frame being sent.
  logic [7:0] frame_bytes [$];

  // Words expected on the rsp channel, oldest first, and the words produced
  // by the latest call of the reply predictor.
  rsp_t echo_queue [$];
  rsp_t fresh_words [$];

  // State of the reply predictor.
  logic [7:0] held_hdr [HdrLen];
  int         held_cnt = 0;
  logic       passing = 1'b0;
  logic [1:0] cur_kind = KindOther;

  // Directed frames: the two ends of a short frame, a frame of exactly the
  // header length, checksum carries, a reply, and some ways of failing
  // classification. The random frames cover the rest.
  frame_row_t plan [8] = '{
    '{ShapeNonIp,     1,  'h00, 1'b0, 16'h0000, 1'b1, KindOther},
    '{ShapeNoise,     1,  'hFF, 1'b0, 16'h0000, 1'b1, KindOther},
    '{ShapeReq,       49, 'hFF, 1'b0, 16'h0000, 1'b1, KindOther},
    '{ShapeReq,       50, 'hFF, 1'b1, 16'hFFFF, 1'b0, KindOther},
    '{ShapeReq,       51, -1,   1'b1, 16'hF7FF, 1'b0, KindOther},
    '{ShapeRep,       51, -1,   1'b0, 16'h0000, 1'b1, KindRep},
    '{ShapeBadVer,    50, 'hFF, 1'b0, 16'h0000, 1'b1, KindOther},
    '{ShapeOtherType, 51, 'h00, 1'b0, 16'h0000, 1'b1, KindOther}
  };

  icmp_echo_reply_rewriter dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_word  (req_word),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_word  (rsp_word)
  );

  always #1 clk = ~clk;

  // The run is cut off once the cycle count passes CycleLimit, in case the block stops making progress.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // The receiver stalls at random except during the steady stretch.
  always @(posedge clk) begin
    rsp_ready <= steady || ($urandom_range(99) >= IdlePct);
  end

  // Writes one header byte when the frame is long enough to hold it.
  function automatic void set_byte(input int idx, input logic [7:0] v);
    if (idx < frame_bytes.size()) frame_bytes[idx] = v;
  endfunction

  // Fills frame_bytes with a frame of the row's shape. Except for noise, fields that the
  // shape does not spoil are set so that the frame reads as an ICMP echo request.
  task automatic build_frame(input frame_row_t r);
    logic [7:0] v;
    frame_bytes.delete();
    for (int i = 0; i < r.len; i++) begin
      frame_bytes.push_back((r.fill < 0) ? 8'($urandom) : 8'(r.fill));
    end
    if (r.shape == ShapeNoise) return;
    set_byte(12, EtypeIp4[15:8]);
    set_byte(13, EtypeIp4[7:0]);
    // Only the version nibble is forced; the header length nibble keeps its fill value.
    v = (frame_bytes.size() > 14) ? frame_bytes[14] : 8'h00;
    set_byte(14, {IpVer4, v[3:0]});
    set_byte(23, ProtoIcmp);
    set_byte(34, IcmpReq);
    case (r.shape)
      ShapeNonIp: begin
        set_byte(12, 8'h86);
        set_byte(13, 8'hDD);
      end
      ShapeBadVer: set_byte(14, {IpVer4 ^ 4'($urandom_range(1, 15)), v[3:0]});
      ShapeBadProto: set_byte(23, ProtoIcmp ^ 8'($urandom_range(1, 255)));
      ShapeOtherType: begin
        do v = 8'($urandom); while (v == IcmpReq || v == IcmpRep);
        set_byte(34, v);
      end
      ShapeRep: set_byte(34, IcmpRep);
      default: ;
    endcase
    if (r.ck_set) begin
      set_byte(36, r.ck[15:8]);
      set_byte(37, r.ck[7:0]);
    end
  endtask

  // Behavioral rewriter: takes one accepted word and leaves the words it
  // causes in fresh_words.
  task automatic predict_reply(input req_t w);
    logic [7:0]  t;
    logic [19:0] acc;
    logic [16:0] ck;
    fresh_words.delete();

    // After the header, bytes flow straight through with the frame's kind.
    if (passing) begin
      fresh_words.push_back('{out_byte: w.frame_byte, out_end: w.frame_end,
                              frame_kind: cur_kind});
      if (w.frame_end) begin
        passing = 1'b0;
        cur_kind = KindOther;
      end
      return;
    end

    held_hdr[held_cnt] = w.frame_byte;
    held_cnt++;

    // A frame that ends before the header is complete comes back unchanged.
    if (held_cnt < HdrLen) begin
      if (w.frame_end) begin
        for (int k = 0; k < held_cnt; k++) begin
          fresh_words.push_back('{out_byte: held_hdr[k], out_end: k == held_cnt - 1,
                                  frame_kind: KindOther});
        end
        held_cnt = 0;
      end
      return;
    end

    // The header is complete: classify it.
    cur_kind = KindOther;
    if ({held_hdr[12], held_hdr[13]} == EtypeIp4 && held_hdr[14][7:4] == IpVer4 &&
        held_hdr[23] == ProtoIcmp) begin
      if (held_hdr[34] == IcmpReq) cur_kind = KindReq;
      else if (held_hdr[34] == IcmpRep) cur_kind = KindRep;
    end

    if (cur_kind == KindReq) begin
      // Swap the MAC addresses, then the IPv4 addresses.
      for (int i = 0; i < 6; i++) begin
        t = held_hdr[i];
        held_hdr[i] = held_hdr[i + 6];
        held_hdr[i + 6] = t;
      end
      for (int i = 26; i < 30; i++) begin
        t = held_hdr[i];
        held_hdr[i] = held_hdr[i + 4];
        held_hdr[i + 4] = t;
      end
      // New IP checksum over the fixed 20-byte header, options ignored.
      held_hdr[24] = 8'h00;
      held_hdr[25] = 8'h00;
      acc = '0;
      for (int i = 14; i < 34; i += 2) acc += {4'h0, held_hdr[i], held_hdr[i + 1]};
      acc = {4'h0, acc[15:0]} + {16'h0, acc[19:16]};
      acc = {4'h0, acc[15:0]} + {16'h0, acc[19:16]};
      {held_hdr[24], held_hdr[25]} = ~acc[15:0];
      // Echo reply type, and the ICMP checksum adjusted for the type change.
      held_hdr[34] = IcmpRep;
      ck = {1'b0, held_hdr[36], held_hdr[37]} + {1'b0, IcmpFix};
      if (ck[16]) ck = {1'b0, ck[15:0]} + 17'd1;
      {held_hdr[36], held_hdr[37]} = ck[15:0];
    end

    for (int k = 0; k < HdrLen; k++) begin
      fresh_words.push_back('{out_byte: held_hdr[k],
                              out_end: (k == HdrLen - 1) && w.frame_end,
                              frame_kind: cur_kind});
    end
    held_cnt = 0;
    passing = !w.frame_end;
    if (w.frame_end) cur_kind = KindOther;
  endtask

  // Sends one frame, one byte per word. Valid is only lowered for an idle
  // cycle, so back-to-back words keep it high across the edge.
  task automatic send_frame(input frame_row_t r);
    req_t w;
    build_frame(r);
    for (int i = 0; i < frame_bytes.size(); i++) begin
      w.frame_byte = frame_bytes[i];
      w.frame_end = (i == frame_bytes.size() - 1);
      while (!steady && $urandom_range(99) < IdlePct) begin
        req_valid <= 1'b0;
        @(posedge clk);
      end
      req_valid <= 1'b1;
      req_word <= w;
      do @(posedge clk); while (!req_ready);
      // The word was accepted at this edge; the predictor always runs so its
      // state follows the block, even where the row gives the answer.
      predict_reply(w);
      if (r.typed) begin
        echo_queue.push_back('{out_byte: w.frame_byte, out_end: w.frame_end,
                               frame_kind: r.kind});
      end else begin
        foreach (fresh_words[k]) echo_queue.push_back(fresh_words[k]);
      end
    end
  endtask

  // Every returned word is compared with the oldest expectation.
  always @(posedge clk) begin : check_words
    rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (echo_queue.size() == 0) begin
        $error("unexpected word: out_byte %02h out_end %0b frame_kind %0d",
               rsp_word.out_byte, rsp_word.out_end, rsp_word.frame_kind);
        errors++;
      end else begin
        want = echo_queue.pop_front();
        if (rsp_word.out_byte !== want.out_byte) begin
          $error("out_byte: expected %02h, actual %02h", want.out_byte, rsp_word.out_byte);
          errors++;
        end
        if (rsp_word.out_end !== want.out_end) begin
          $error("out_end: expected %0b, actual %0b", want.out_end, rsp_word.out_end);
          errors++;
        end
        if (rsp_word.frame_kind !== want.frame_kind) begin
          $error("frame_kind: expected %0d, actual %0d", want.frame_kind,
                 rsp_word.frame_kind);
          errors++;
        end
      end
    end
  end

  initial begin
    frame_row_t row;
    int sent_random;
    int pick;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) send_frame(plan[i]);

    // Random frames: mostly well-formed requests and replies with random
    // content, with some short frames, broken headers and plain noise. A
    // long stretch runs with no idle cycles on either side.
    sent_random = 0;
    while (sent_random < RandomBytes) begin
      steady = (sent_random >= 10 && sent_random < 100);
      pick = $urandom_range(99);
      row.shape = (pick < 45) ? ShapeReq :
                  (pick < 60) ? ShapeRep :
                  (pick < 65) ? ShapeNonIp :
                  (pick < 70) ? ShapeBadVer :
                  (pick < 75) ? ShapeBadProto :
                  (pick < 80) ? ShapeOtherType : ShapeNoise;
      if ($urandom_range(99) < 20) row.len = $urandom_range(1, HdrLen - 1);
      else if ($urandom_range(3) == 0) row.len = HdrLen;
      else row.len = $urandom_range(HdrLen + 1, 90);
      row.fill = -1;
      row.ck_set = ($urandom_range(4) == 0);
      pick = $urandom_range(2);
      row.ck = (pick == 0) ? 16'hFFFF : (pick == 1) ? 16'hF7FF : 16'hF800;
      row.typed = 1'b0;
      row.kind = KindOther;
      send_frame(row);
      sent_random += row.len;
    end
    steady = 1'b0;
    req_valid <= 1'b0;

    // Drain, then give the block time to show any stray word.
    while (echo_queue.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);

    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/icmp_rw_pkg.sv
hw/rtl/icmp_echo_reply_rewriter.sv
hw/rtl/icmp_rw_checker.sv
bench/tb_icmp_echo_reply_rewriter.sv
